// ----- rtl/baft_pkg.sv -----
// Shared types and codes for the bitmap block allocator with file table.
package baft_pkg;

	// request codes
	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_LIST   = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_TABLE_FULL = 3'd1;
	localparam logic [2:0] ST_DISK_FULL  = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
	localparam logic [2:0] ST_EMPTY      = 3'd4;

	// payload widths
	localparam int NAME_W   = 64;
	localparam int SIZE_W   = 32;
	localparam int SLOT_W   = 4;
	localparam int BLOCK_W  = 5;

	// a list request gives at most this many beats
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS);

	// broadcast commands to the row of slot cells
	typedef struct packed {
		logic create;     // write the lowest free slot
		logic remove;     // drop the lowest matching slot
		logic list_load;  // snapshot valid marks into the pending marks
		logic list_step;  // retire the lowest pending mark
	} baft_cmd_t;

	// per-cell flags back to the controller
	typedef struct packed {
		logic grant_free;
		logic grant_hit;
		logic pick;
	} baft_lane_t;

endpackage

// ----- rtl/baft_slot_cell.sv -----
// One file table slot: entry storage plus its links in the priority chains.
module baft_slot_cell import baft_pkg::*; #(
	parameter int BW = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  baft_cmd_t         cmd,
	input  logic [NAME_W-1:0] key,
	input  logic [SIZE_W-1:0] size,
	input  logic [BW-1:0]     blk,
	input  logic              free_in,
	output logic              free_out,
	input  logic              hit_in,
	output logic              hit_out,
	input  logic              pend_in,
	output logic              pend_out,
	input  logic              twice_in,
	output logic              twice_out,
	output baft_lane_t        lane,
	output logic [NAME_W-1:0] cell_name,
	output logic [BW-1:0]     cell_start,
	output logic [SIZE_W-1:0] cell_size
);

	logic              valid_q;
	logic              pend_q;
	logic [NAME_W-1:0] name_q;
	logic [BW-1:0]     start_q;
	logic [SIZE_W-1:0] size_q;
	logic              match;

	assign match           = valid_q && (name_q == key);
	assign lane.grant_free = !valid_q && !free_in;
	assign lane.grant_hit  = match && !hit_in;
	assign lane.pick       = pend_q && !pend_in;
	assign free_out        = free_in || !valid_q;
	assign hit_out         = hit_in || match;
	assign pend_out        = pend_in || pend_q;
	// a second pending mark seen further along the row
	assign twice_out       = twice_in || (pend_q && pend_in);

	assign cell_name  = name_q;
	assign cell_start = start_q;
	assign cell_size  = size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			if (cmd.create && lane.grant_free) begin
				valid_q <= 1'b1;
			end else if (cmd.remove && lane.grant_hit) begin
				valid_q <= 1'b0;
			end
			if (cmd.list_load) begin
				pend_q <= valid_q;
			end else if (cmd.list_step && lane.pick) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.create && lane.grant_free) begin
			name_q  <= key;
			start_q <= blk;
			size_q  <= size;
		end
	end

endmodule

// ----- rtl/baft_block_cell.sv -----
// One disk block: used mark and its link in the lowest-free chain.
module baft_block_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic alloc,
	input  logic release_blk,
	input  logic free_in,
	output logic free_out,
	output logic grant
);

	logic used_q;

	assign grant    = !used_q && !free_in;
	assign free_out = free_in || !used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (alloc && grant) begin
			used_q <= 1'b1;
		end else if (release_blk) begin
			used_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/bitmap_block_allocator_file_table.sv -----
// Top level: free-block bitmap allocator with a small file table.
//
// Usage
//   A request beat is taken at a rising edge where start is high and busy is
//   low: operation, name_key and file_size are sampled there. Only the low
//   NAME_BYTES bytes of name_key are kept and compared.
//   Results leave as beats on status, slot_index, block_index, entry_name,
//   entry_size and last, each marked by valid for exactly one cycle. There
//   is no back-pressure: the receiver must take every beat as it comes.
// Sequencing
//   Create and delete: the request edge starts an execute cycle; the result
//   beat follows in the next cycle, and busy is already low then, so a new
//   request can be taken as the beat shows. List: one beat per cycle, one per
//   valid slot (at most 16, or a single empty beat); busy stays high until
//   the final beat is produced, and the next request is taken after the list.
//   The pace is set by the row of slot cells: each cycle
//   the priority chains through the row resolve one grant (lowest free slot,
//   lowest matching name, or lowest pending entry while listing), and the
//   block bitmap chain resolves the lowest free block.
//   Operation code 3 is taken and dropped: no beat, no change.
// Reset
//   arst_n clears every block mark, every slot valid mark and the
//   controller; slot contents are left as they are until written.
module bitmap_block_allocator_file_table import baft_pkg::*; #(
	parameter int FILE_SLOTS  = 16,
	parameter int DISK_BLOCKS = 32,
	parameter int NAME_BYTES  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [NAME_W-1:0]  name_key,
	input  logic [SIZE_W-1:0]  file_size,
	output logic               valid,
	output logic [2:0]         status,
	output logic [SLOT_W-1:0]  slot_index,
	output logic [BLOCK_W-1:0] block_index,
	output logic [NAME_W-1:0]  entry_name,
	output logic [SIZE_W-1:0]  entry_size,
	output logic               last
);

	localparam int SW  = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
	localparam int BW  = (DISK_BLOCKS > 1) ? $clog2(DISK_BLOCKS) : 1;
	localparam int SWX = (SW > SLOT_W) ? SW : SLOT_W;
	localparam int BWX = (BW > BLOCK_W) ? BW : BLOCK_W;
	localparam logic [NAME_W-1:0] KEY_MASK = (NAME_BYTES >= 8) ? {NAME_W{1'b1}} :
		((NAME_W'(1) << (NAME_BYTES * 8)) - NAME_W'(1));

	// request register and controller
	logic              busy_q;
	logic [1:0]        op_q;
	logic [NAME_W-1:0] key_q;
	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  n_q;
	logic              accept;

	// result registers
	logic               valid_q;
	logic [2:0]         status_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [BLOCK_W-1:0] block_q;
	logic [NAME_W-1:0]  name_q;
	logic [SIZE_W-1:0]  size_out_q;
	logic               last_q;

	// slot row
	baft_cmd_t         cmd;
	baft_lane_t        lane [FILE_SLOTS];
	logic [NAME_W-1:0] lane_name [FILE_SLOTS];
	logic [BW-1:0]     lane_start [FILE_SLOTS];
	logic [SIZE_W-1:0] lane_size [FILE_SLOTS];
	logic [FILE_SLOTS:0] free_c, hit_c, pend_c, twice_c;
	logic [FILE_SLOTS-1:0] grant_free_v, sel_v;

	// block row
	logic [DISK_BLOCKS:0]   bfree_c;
	logic [DISK_BLOCKS-1:0] bgrant_v, brelease_v;
	logic                   alloc;

	// selections
	logic [SWX-1:0]    free_idx_x, sel_idx_x;
	logic [BWX-1:0]    blk_idx_x;
	logic [NAME_W-1:0] sel_name;
	logic [BW-1:0]     sel_start;
	logic [SIZE_W-1:0] sel_size;
	logic [BWX-1:0]    sel_start_x;
	logic              free_any, hit_any, pend_any, more_pend, blk_any, is_list;

	// result of this execute cycle
	logic               res_done;
	logic [2:0]         res_status;
	logic [SLOT_W-1:0]  res_slot;
	logic [BLOCK_W-1:0] res_block;
	logic [NAME_W-1:0]  res_name;
	logic [SIZE_W-1:0]  res_size;
	logic               res_last;

	assign accept = start && !busy_q;

	assign free_c[0]  = 1'b0;
	assign hit_c[0]   = 1'b0;
	assign pend_c[0]  = 1'b0;
	assign twice_c[0] = 1'b0;

	for (genvar i = 0; i < FILE_SLOTS; i++) begin : g_slot
		baft_slot_cell #(.BW(BW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.key        (key_q),
			.size       (size_q),
			.blk        (blk_idx_x[BW-1:0]),
			.free_in    (free_c[i]),
			.free_out   (free_c[i+1]),
			.hit_in     (hit_c[i]),
			.hit_out    (hit_c[i+1]),
			.pend_in    (pend_c[i]),
			.pend_out   (pend_c[i+1]),
			.twice_in   (twice_c[i]),
			.twice_out  (twice_c[i+1]),
			.lane       (lane[i]),
			.cell_name  (lane_name[i]),
			.cell_start (lane_start[i]),
			.cell_size  (lane_size[i])
		);
		assign grant_free_v[i] = lane[i].grant_free;
		assign sel_v[i]        = is_list ? lane[i].pick : lane[i].grant_hit;
	end

	assign bfree_c[0] = 1'b0;

	for (genvar j = 0; j < DISK_BLOCKS; j++) begin : g_block
		baft_block_cell u_blk (
			.clk         (clk),
			.arst_n      (arst_n),
			.alloc       (alloc),
			.release_blk (brelease_v[j]),
			.free_in     (bfree_c[j]),
			.free_out    (bfree_c[j+1]),
			.grant       (bgrant_v[j])
		);
		assign brelease_v[j] = cmd.remove && (sel_start == BW'(j));
	end

	assign free_any  = free_c[FILE_SLOTS];
	assign hit_any   = hit_c[FILE_SLOTS];
	assign pend_any  = pend_c[FILE_SLOTS];
	assign more_pend = twice_c[FILE_SLOTS];
	assign blk_any   = bfree_c[DISK_BLOCKS];
	assign is_list   = (op_q == OP_LIST);

	assign cmd.create    = busy_q && (op_q == OP_CREATE) && free_any && blk_any;
	assign cmd.remove    = busy_q && (op_q == OP_DELETE) && hit_any;
	assign cmd.list_load = accept && (operation == OP_LIST);
	assign cmd.list_step = busy_q && is_list && pend_any;
	assign alloc         = cmd.create;

	// one-hot grants to indices and entry data
	always_comb begin
		free_idx_x = '0;
		sel_idx_x  = '0;
		sel_name   = '0;
		sel_start  = '0;
		sel_size   = '0;
		for (int i = 0; i < FILE_SLOTS; i++) begin
			if (grant_free_v[i]) begin
				free_idx_x = free_idx_x | SWX'(i);
			end
			if (sel_v[i]) begin
				sel_idx_x = sel_idx_x | SWX'(i);
				sel_name  = sel_name | lane_name[i];
				sel_start = sel_start | lane_start[i];
				sel_size  = sel_size | lane_size[i];
			end
		end
	end

	always_comb begin
		blk_idx_x = '0;
		for (int j = 0; j < DISK_BLOCKS; j++) begin
			if (bgrant_v[j]) begin
				blk_idx_x = blk_idx_x | BWX'(j);
			end
		end
	end

	assign sel_start_x = BWX'(sel_start);

	// result of the current execute cycle
	always_comb begin
		res_done   = 1'b1;
		res_status = ST_OK;
		res_slot   = '0;
		res_block  = '0;
		res_name   = '0;
		res_size   = '0;
		res_last   = 1'b1;
		case (op_q)
			OP_CREATE: begin
				if (!free_any) begin
					res_status = ST_TABLE_FULL;
				end else if (!blk_any) begin
					res_status = ST_DISK_FULL;
				end else begin
					res_slot  = free_idx_x[SLOT_W-1:0];
					res_block = blk_idx_x[BLOCK_W-1:0];
					res_name  = key_q;
					res_size  = size_q;
				end
			end
			OP_DELETE: begin
				if (!hit_any) begin
					res_status = ST_NOT_FOUND;
				end else begin
					res_slot  = sel_idx_x[SLOT_W-1:0];
					res_block = sel_start_x[BLOCK_W-1:0];
					res_name  = sel_name;
					res_size  = sel_size;
				end
			end
			OP_LIST: begin
				if (!pend_any) begin
					res_status = ST_EMPTY;
				end else begin
					res_slot  = sel_idx_x[SLOT_W-1:0];
					res_block = sel_start_x[BLOCK_W-1:0];
					res_name  = sel_name;
					res_size  = sel_size;
					res_last  = !more_pend || (n_q == CNT_W'(MAX_RESULTS - 1));
					res_done  = res_last;
				end
			end
			default: begin
				res_done = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			n_q     <= '0;
		end else begin
			valid_q <= busy_q;
			if (busy_q) begin
				busy_q <= !res_done;
				n_q    <= n_q + CNT_W'(1);
			end else if (accept && (operation != OP_NOP)) begin
				busy_q <= 1'b1;
				n_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			key_q  <= name_key & KEY_MASK;
			size_q <= file_size;
		end
		if (busy_q) begin
			status_q   <= res_status;
			slot_q     <= res_slot;
			block_q    <= res_block;
			name_q     <= res_name;
			size_out_q <= res_size;
			last_q     <= res_last;
		end
	end

	assign busy        = busy_q;
	assign valid       = valid_q;
	assign status      = status_q;
	assign slot_index  = slot_q;
	assign block_index = block_q;
	assign entry_name  = name_q;
	assign entry_size  = size_out_q;
	assign last        = last_q;

	// a result beat only ever follows an execute cycle
	a_valid_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> $past(busy_q))
		else $error("result beat without execute cycle");

	// at most one cell granted on each of the three chains
	a_grant_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(grant_free_v) && $onehot0(sel_v) && $onehot0(bgrant_v))
		else $error("priority chain granted more than one cell");

	// create and delete never keep the block busy past their execute cycle
	a_single_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !is_list) |=> !busy_q)
		else $error("create or delete held the block busy");

	// the controller leaves busy only on a final beat
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !res_last) |=> busy_q)
		else $error("busy dropped before the final beat");

endmodule
